// ===== design/gtpd_pkg.sv =====
package gtpd_pkg;

   // Transaction kinds on the request channel
   typedef enum logic {
      REQ_START  = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   // Turn direction codes
   typedef logic [1:0] dir_type;
   localparam dir_type DIR_LEFT  = 2'd1;
   localparam dir_type DIR_RIGHT = 2'd2;

   // Register map
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_KP_GAIN        = 3'd0;
   localparam csr_index_type CSR_KD_GAIN        = 3'd1;
   localparam csr_index_type CSR_MAX_POWER      = 3'd2;
   localparam csr_index_type CSR_MIN_POWER      = 3'd3;
   localparam csr_index_type CSR_SETTLE_PERIODS = 3'd4;

   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [15:0] KP_GAIN_RESET        = 16'd512;
   localparam logic [15:0] KD_GAIN_RESET        = 16'd38;
   localparam logic [6:0]  MAX_POWER_RESET      = 7'd90;
   localparam logic [6:0]  MIN_POWER_RESET      = 7'd25;
   localparam logic [9:0]  SETTLE_PERIODS_RESET = 10'd50;

   localparam logic [9:0]  SETTLE_MAX = 10'd1023;

endpackage

// ===== design/gyro_turn_pd_controller.sv =====
// Gyro turn PD controller with output clamp.
// A request passes through the input register, then the result register;
//   one transaction per cycle while rsp_ready does not stall the output, set by the
//   single-pass PD datapath between the two registers.
// Reset (synchronous, active high): empties both registers, restores the gain and
//   power registers to their defaults and clears heading target and settle state.
module gyro_turn_pd_controller (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [1:0]                          req_direction,
   input  logic [11:0]                         req_target_degrees,
   input  logic signed [15:0]                  req_gyro_reading,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [7:0]                   rsp_yaw_drive,
   output logic signed [17:0]                  rsp_heading_error,
   output logic                                rsp_done_res,
   // register write port
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [gtpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [15:0] kp_gain_ff;
   logic [15:0] kd_gain_ff;
   logic [6:0]  max_power_ff;
   logic [6:0]  min_power_ff;
   logic [9:0]  settle_periods_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff        <= gtpd_pkg::KP_GAIN_RESET;
         kd_gain_ff        <= gtpd_pkg::KD_GAIN_RESET;
         max_power_ff      <= gtpd_pkg::MAX_POWER_RESET;
         min_power_ff      <= gtpd_pkg::MIN_POWER_RESET;
         settle_periods_ff <= gtpd_pkg::SETTLE_PERIODS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            gtpd_pkg::CSR_KP_GAIN:        kp_gain_ff        <= csr_wdata;
            gtpd_pkg::CSR_KD_GAIN:        kd_gain_ff        <= csr_wdata;
            gtpd_pkg::CSR_MAX_POWER:      max_power_ff      <= csr_wdata[6:0];
            gtpd_pkg::CSR_MIN_POWER:      min_power_ff      <= csr_wdata[6:0];
            gtpd_pkg::CSR_SETTLE_PERIODS: settle_periods_ff <= csr_wdata[9:0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: input register feeds result register; both advance together
   // when the input holds a request and the result slot is free or being drained.
   // ---------------------------------------------------------------
   logic in_valid_ff;
   logic rsp_valid_ff;
   logic advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   gtpd_pkg::req_kind_type in_kind_ff;
   logic [1:0]             in_dir_ff;
   logic [11:0]            in_deg_ff;
   logic signed [15:0]     in_gyro_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= gtpd_pkg::req_kind_type'(req_type);
         in_dir_ff  <= req_direction;
         in_deg_ff  <= req_target_degrees;
         in_gyro_ff <= req_gyro_reading;
      end
   end

   // ---------------------------------------------------------------
   // Controller state
   // ---------------------------------------------------------------
   logic signed [17:0] target_heading_ff, target_heading_in;
   logic signed [17:0] last_error_ff,     last_error_in;
   logic               timer_running_ff,  timer_running_in;
   logic [9:0]         settle_count_ff,   settle_count_in;
   logic               turn_done_ff,      turn_done_in;

   // ---------------------------------------------------------------
   // PD datapath
   // ---------------------------------------------------------------
   logic signed [17:0] gyro_ext;
   logic signed [17:0] deg_ext;
   logic signed [17:0] start_target;
   logic signed [17:0] err_start;
   logic signed [17:0] err_run;
   logic signed [18:0] delta;
   logic signed [34:0] prod_p;
   logic signed [35:0] prod_d;
   logic signed [36:0] pd_sum;
   logic               round_up;
   logic [28:0]        quot_raw;
   logic signed [28:0] quot;
   logic signed [28:0] min_s;
   logic signed [28:0] max_s;
   logic signed [28:0] raised;
   logic signed [28:0] clamped;
   logic signed [7:0]  yaw_pd;
   logic               err_zero;
   logic               err_big;
   logic               timer_next;
   logic [9:0]         count_next;
   logic               done_next;

   assign gyro_ext = 18'(in_gyro_ff);
   assign deg_ext  = $signed({6'b0, in_deg_ff});

   always_comb begin
      unique case (in_dir_ff)
         gtpd_pkg::DIR_LEFT:  start_target = gyro_ext + deg_ext;
         gtpd_pkg::DIR_RIGHT: start_target = gyro_ext - deg_ext;
         default:             start_target = gyro_ext;
      endcase
   end

   assign err_start = start_target - gyro_ext;
   assign err_run   = target_heading_ff - gyro_ext;   // wraps to 18 bits
   assign delta     = 19'(err_run) - 19'(last_error_ff);

   // Gains are unsigned Q8.8; zero-extend before the signed multiply
   assign prod_p = $signed({1'b0, kp_gain_ff}) * err_run;
   assign prod_d = $signed({1'b0, kd_gain_ff}) * delta;
   assign pd_sum = 37'(prod_p) + 37'(prod_d);

   // Divide by 256, truncating toward zero
   assign round_up = pd_sum[36] && (|pd_sum[7:0]);
   assign quot_raw = pd_sum[36:8] + 29'(round_up);
   assign quot     = $signed(quot_raw);

   assign min_s = $signed({22'b0, min_power_ff});
   assign max_s = $signed({22'b0, max_power_ff});

   // Raise small nonzero outputs to the minimum, then saturate at max
   always_comb begin
      if (quot > 29'sd0 && quot < min_s) begin
         raised = min_s;
      end else if (quot < 29'sd0 && quot > -min_s) begin
         raised = -min_s;
      end else begin
         raised = quot;
      end
      if (raised > max_s) begin
         clamped = max_s;
      end else if (raised < -max_s) begin
         clamped = -max_s;
      end else begin
         clamped = raised;
      end
   end

   assign yaw_pd = 8'(-clamped);

   // Settle timer: starts on zero error, stops once |error| exceeds one
   assign err_zero = (err_run == 18'sd0);
   assign err_big  = (err_run > 18'sd1) || (err_run < -18'sd1);

   always_comb begin
      timer_next = timer_running_ff;
      count_next = settle_count_ff;
      if (err_zero && !timer_running_ff) begin
         timer_next = 1'b1;
         count_next = '0;
      end else if (err_big) begin
         timer_next = 1'b0;
         count_next = '0;
      end
      done_next = 1'b0;
      if (timer_next) begin
         if (count_next < gtpd_pkg::SETTLE_MAX) begin
            count_next = count_next + 10'd1;
         end
         done_next = (count_next >= settle_periods_ff);
      end
   end

   // ---------------------------------------------------------------
   // Next state and result
   // ---------------------------------------------------------------
   logic signed [7:0]  yaw_in;
   logic signed [17:0] err_in;
   logic               done_res_in;

   always_comb begin
      target_heading_in = target_heading_ff;
      last_error_in     = last_error_ff;
      timer_running_in  = timer_running_ff;
      settle_count_in   = settle_count_ff;
      turn_done_in      = turn_done_ff;
      yaw_in            = '0;
      err_in            = err_run;
      done_res_in       = 1'b0;
      priority if (in_kind_ff == gtpd_pkg::REQ_START) begin
         target_heading_in = start_target;
         last_error_in     = deg_ext;
         timer_running_in  = 1'b0;
         settle_count_in   = '0;
         turn_done_in      = 1'b0;
         err_in            = err_start;
      end else if (turn_done_ff) begin
         // settled: hold state, drive stays off
         done_res_in = 1'b1;
      end else begin
         last_error_in    = err_run;
         timer_running_in = timer_next;
         settle_count_in  = count_next;
         turn_done_in     = done_next;
         yaw_in           = done_next ? 8'sd0 : yaw_pd;
         done_res_in      = done_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         target_heading_ff <= '0;
         last_error_ff     <= '0;
         timer_running_ff  <= 1'b0;
         settle_count_ff   <= '0;
         turn_done_ff      <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff      <= 1'b1;
            target_heading_ff <= target_heading_in;
            last_error_ff     <= last_error_in;
            timer_running_ff  <= timer_running_in;
            settle_count_ff   <= settle_count_in;
            turn_done_ff      <= turn_done_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   logic signed [7:0]  rsp_yaw_ff;
   logic signed [17:0] rsp_err_ff;
   logic               rsp_done_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_yaw_ff  <= yaw_in;
         rsp_err_ff  <= err_in;
         rsp_done_ff <= done_res_in;
      end
   end

   assign rsp_yaw_drive     = rsp_yaw_ff;
   assign rsp_heading_error = rsp_err_ff;
   assign rsp_done_res      = rsp_done_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // A start transaction always yields a stopped, not-done response
   a_start_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && (in_kind_ff == gtpd_pkg::REQ_START)
         |=> rsp_valid && !rsp_done_res && (rsp_yaw_drive == 8'sd0))
      else $error("start transaction produced nonzero drive or done");

   // Done means the drive is stopped
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> (rsp_yaw_drive == 8'sd0))
      else $error("done response with nonzero yaw drive");

   // Back-pressure only when both registers are full and the output is stalled
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid && !rsp_ready)
      else $error("request not ready without a full, stalled pipeline");

   // Settle counter only runs while the timer is on
   a_count_timer: assert property (@(posedge clock) disable iff (reset)
      !timer_running_ff |-> (settle_count_ff == 10'd0))
      else $error("settle count nonzero with timer stopped");

endmodule

// ===== dv/gyro_turn_pd_controller_tb.sv =====
module gyro_turn_pd_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Direction codes with no package name: both mean "no offset"
   localparam gtpd_pkg::dir_type DIR_NONE  = 2'd0;
   localparam gtpd_pkg::dir_type DIR_SPARE = 2'd3;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RSP_HOLD_CYCLES = 60;
   localparam int PHASE_ITEMS     = 190;
   localparam int NUM_PHASES      = 6;

   // One response transaction
   typedef struct packed {
      logic signed [7:0]  yaw;
      logic signed [17:0] err;
      logic               done;
   } turn_result_type;

   // Full register image
   typedef struct packed {
      logic [15:0] kp;
      logic [15:0] kd;
      logic [6:0]  maxp;
      logic [6:0]  minp;
      logic [9:0]  settle;
   } gain_set_type;

   // Directed table row: gain_sel picks the register image the row runs under,
   // typed says the response is given in the row instead of predicted
   typedef struct packed {
      logic [1:0]             gain_sel;
      gtpd_pkg::req_kind_type kind;
      gtpd_pkg::dir_type      dir;
      logic [11:0]            deg;
      logic signed [15:0]     gyro;
      logic                   typed;
      turn_result_type        rsp;
   } turn_stim_type;

   localparam turn_result_type NO_RSP = '0;

   localparam gain_set_type GAIN_SETS [4] = '{
      '{gtpd_pkg::KP_GAIN_RESET, gtpd_pkg::KD_GAIN_RESET, gtpd_pkg::MAX_POWER_RESET,
        gtpd_pkg::MIN_POWER_RESET, gtpd_pkg::SETTLE_PERIODS_RESET},
      '{16'hFFFF, 16'hFFFF, 7'd127, 7'd127, 10'd0},   // max gains, min == max, instant settle
      '{16'd1, 16'd0, 7'd10, 7'd100, 10'd2},          // minimum above maximum
      '{16'd0, 16'd0, 7'd0, 7'd0, 10'd1023}           // zero gains, longest settle
   };

   localparam turn_stim_type DIRECTED_ROWS [25] = '{
      // samples before any start run against a zero target
      '{2'd0, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd0, 1'b1,
        '{8'sd0, 18'sd0, 1'b0}},
      '{2'd0, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd32767, 1'b1,
        '{8'sd90, -18'sd32767, 1'b0}},
      '{2'd0, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sh8000, 1'b1,
        '{-8'sd90, 18'sd32768, 1'b0}},
      // starts at the heading extremes, both directions, and no-offset codes
      '{2'd0, gtpd_pkg::REQ_START, gtpd_pkg::DIR_LEFT, 12'd3600, 16'sd32767, 1'b1,
        '{8'sd0, 18'sd3600, 1'b0}},
      '{2'd0, gtpd_pkg::REQ_START, gtpd_pkg::DIR_RIGHT, 12'd3600, 16'sh8000, 1'b1,
        '{8'sd0, -18'sd3600, 1'b0}},
      '{2'd0, gtpd_pkg::REQ_START, DIR_NONE, 12'd1234, 16'sd100, 1'b1,
        '{8'sd0, 18'sd0, 1'b0}},
      '{2'd0, gtpd_pkg::REQ_START, DIR_SPARE, 12'd3600, -16'sd5, 1'b1,
        '{8'sd0, 18'sd0, 1'b0}},
      // first sample after start sees last error == degrees
      '{2'd0, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, -16'sd5, 1'b0, NO_RSP},
      '{2'd0, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, -16'sd4, 1'b0, NO_RSP},
      '{2'd0, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, -16'sd6, 1'b0, NO_RSP},
      '{2'd0, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, -16'sd200, 1'b0, NO_RSP},
      '{2'd0, gtpd_pkg::REQ_START, gtpd_pkg::DIR_LEFT, 12'd0, 16'sd0, 1'b1,
        '{8'sd0, 18'sd0, 1'b0}},
      // tiny errors get raised to min power
      '{2'd0, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd1, 1'b0, NO_RSP},
      '{2'd0, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, -16'sd1, 1'b0, NO_RSP},
      // settle of zero: done on the first sample with the timer running
      '{2'd1, gtpd_pkg::REQ_START, gtpd_pkg::DIR_LEFT, 12'd10, 16'sd0, 1'b1,
        '{8'sd0, 18'sd10, 1'b0}},
      '{2'd1, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd0, 1'b0, NO_RSP},
      '{2'd1, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd10, 1'b0, NO_RSP},
      // after done: drive stays off, error still reported
      '{2'd1, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd500, 1'b1,
        '{8'sd0, -18'sd490, 1'b1}},
      // min above max: saturation wins
      '{2'd2, gtpd_pkg::REQ_START, gtpd_pkg::DIR_RIGHT, 12'd5, 16'sd20, 1'b1,
        '{8'sd0, -18'sd5, 1'b0}},
      '{2'd2, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, -16'sd1000, 1'b0, NO_RSP},
      '{2'd2, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd15, 1'b0, NO_RSP},
      '{2'd2, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd16, 1'b0, NO_RSP},
      '{2'd2, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd15, 1'b0, NO_RSP},
      '{2'd3, gtpd_pkg::REQ_START, gtpd_pkg::DIR_LEFT, 12'd1, -16'sd1, 1'b1,
        '{8'sd0, 18'sd1, 1'b0}},
      '{2'd3, gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'sd3, 1'b0, NO_RSP}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid;
   logic                              req_ready;
   logic                              req_type;
   logic [1:0]                        req_direction;
   logic [11:0]                       req_target_degrees;
   logic signed [15:0]                req_gyro_reading;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [7:0]                 rsp_yaw_drive;
   logic signed [17:0]                rsp_heading_error;
   logic                              rsp_done_res;
   logic                              csr_we;
   logic [2:0]                        csr_index;
   logic [gtpd_pkg::CSR_DATA_W-1:0]   csr_wdata;

   gyro_turn_pd_controller dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_direction      (req_direction),
      .req_target_degrees (req_target_degrees),
      .req_gyro_reading   (req_gyro_reading),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_yaw_drive      (rsp_yaw_drive),
      .rsp_heading_error  (rsp_heading_error),
      .rsp_done_res       (rsp_done_res),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the controller: registers and turn state
   gain_set_type       cur_gains = GAIN_SETS[0];
   logic signed [17:0] hdg_target = '0;
   logic signed [17:0] prev_error = '0;
   logic               settle_timer_on = 1'b0;
   logic [9:0]         settle_cnt = '0;
   logic               turn_finished = 1'b0;

   turn_result_type pending_turn_rsp [$];
   int              mismatch_count = 0;
   int              items_sent = 0;
   int              cycle_count = 0;
   int              req_idle_pct = 20;
   int              rsp_idle_pct = 20;
   bit              rsp_hold_req = 1'b0;

   // Expected response for one accepted request; advances the shadow state
   function automatic turn_result_type compute_turn_response(
         input gtpd_pkg::req_kind_type kind,
         input gtpd_pkg::dir_type dir,
         input logic [11:0] deg,
         input logic signed [15:0] gyro);
      turn_result_type r;
      int              g;
      int              t;
      longint          d;
      longint          sum;
      longint          p;
      longint          lo_p;
      longint          hi_p;
      longint          mag;
      g = gyro;
      r = '0;
      if (kind == gtpd_pkg::REQ_START) begin
         t = g;
         if (dir == gtpd_pkg::DIR_LEFT) begin
            t = t + int'(deg);
         end else if (dir == gtpd_pkg::DIR_RIGHT) begin
            t = t - int'(deg);
         end
         hdg_target      = t[17:0];
         prev_error      = {6'd0, deg};
         settle_timer_on = 1'b0;
         settle_cnt      = '0;
         turn_finished   = 1'b0;
         t = int'(hdg_target) - g;
         r.err = t[17:0];
      end else if (turn_finished) begin
         // frozen: drive off, error still reported
         t = int'(hdg_target) - g;
         r.err  = t[17:0];
         r.done = 1'b1;
      end else begin
         t = int'(hdg_target) - g;
         r.err = t[17:0];
         d = longint'(r.err) - longint'(prev_error);
         prev_error = r.err;
         sum = longint'(cur_gains.kp) * longint'(r.err) + longint'(cur_gains.kd) * d;
         p = sum / 256;   // truncates toward zero
         lo_p = longint'(cur_gains.minp);
         hi_p = longint'(cur_gains.maxp);
         if (p > 0 && p < lo_p) begin
            p = lo_p;
         end else if (p < 0 && p > -lo_p) begin
            p = -lo_p;
         end
         if (p > hi_p) begin
            p = hi_p;
         end else if (p < -hi_p) begin
            p = -hi_p;
         end
         r.yaw = 8'(-p);
         mag = (r.err < 0) ? -longint'(r.err) : longint'(r.err);
         // |err| == 1 leaves the timer alone
         if (mag == 0 && !settle_timer_on) begin
            settle_timer_on = 1'b1;
            settle_cnt      = '0;
         end else if (mag > 1) begin
            settle_timer_on = 1'b0;
            settle_cnt      = '0;
         end
         if (settle_timer_on) begin
            if (settle_cnt < gtpd_pkg::SETTLE_MAX) begin
               settle_cnt = settle_cnt + 10'd1;
            end
            if (settle_cnt >= cur_gains.settle) begin
               turn_finished = 1'b1;
            end
         end
         if (turn_finished) begin
            r.yaw = '0;
         end
         r.done = turn_finished;
      end
      return r;
   endfunction

   // Offer one request transaction, hold it until accepted, then log the
   // expected response. Payload goes out with NBAs at the clock edge.
   task automatic send_turn_item(input gtpd_pkg::req_kind_type kind,
                                 input gtpd_pkg::dir_type dir,
                                 input logic [11:0] deg, input logic signed [15:0] gyro,
                                 input bit typed, input turn_result_type typed_rsp);
      turn_result_type want;
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_direction      <= dir;
      req_target_degrees <= deg;
      req_gyro_reading   <= gyro;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = compute_turn_response(kind, dir, deg, gyro);
      pending_turn_rsp.push_back(typed ? typed_rsp : want);
      items_sent++;
   endtask

   // Sender pause: wait for every response, then let the pipe empty
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_turn_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Back-to-back writes of all five registers; only called while idle
   task automatic program_gains(input gain_set_type gs);
      gtpd_pkg::csr_index_type idx [5];
      logic [15:0]             val [5];
      idx = '{gtpd_pkg::CSR_KP_GAIN, gtpd_pkg::CSR_KD_GAIN, gtpd_pkg::CSR_MAX_POWER,
              gtpd_pkg::CSR_MIN_POWER, gtpd_pkg::CSR_SETTLE_PERIODS};
      val = '{gs.kp, gs.kd, {9'd0, gs.maxp}, {9'd0, gs.minp}, {6'd0, gs.settle}};
      for (int k = 0; k < 5; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cur_gains = gs;
   endtask

   // A well-formed turn: start, then samples whose error decays toward zero and
   // dithers by one so the settle timer can run; rare jumps restart it.
   task automatic run_turn_sequence(input int phase_end);
      gtpd_pkg::dir_type dir;
      logic [11:0]       deg;
      int                offset;
      int                lo;
      int                hi;
      int                g0;
      int                target;
      int                e;
      int                len;
      int                gv;
      case ($urandom_range(0, 19))
         0:       dir = DIR_NONE;
         1:       dir = DIR_SPARE;
         2, 3, 4, 5, 6, 7, 8, 9, 10: dir = gtpd_pkg::DIR_LEFT;
         default: dir = gtpd_pkg::DIR_RIGHT;
      endcase
      deg = ($urandom_range(0, 2) != 0) ? 12'($urandom_range(0, 60))
                                        : 12'($urandom_range(0, 3600));
      offset = (dir == gtpd_pkg::DIR_LEFT)  ? int'(deg) :
               (dir == gtpd_pkg::DIR_RIGHT) ? -int'(deg) : 0;
      // keep the target reachable by a 16-bit gyro
      lo = -32768 - ((offset < 0) ? offset : 0);
      hi = 32767 - ((offset > 0) ? offset : 0);
      g0 = lo + int'($urandom_range(0, hi - lo));
      target = g0 + offset;
      send_turn_item(gtpd_pkg::REQ_START, dir, deg, 16'(g0), 1'b0, NO_RSP);
      e = offset;
      len = int'(cur_gains.settle) + int'($urandom_range(4, 14));
      if (len > 70) len = 70;
      if (len > phase_end - items_sent) len = phase_end - items_sent;
      for (int n = 0; n < len; n++) begin
         if ($urandom_range(0, 24) == 0) begin
            e = int'($urandom_range(0, 600)) - 300;
         end else if (e > 2 || e < -2) begin
            e = e / 2 + int'($urandom_range(0, 2)) - 1;
         end else begin
            case ($urandom_range(0, 5))
               0:       e = -1;
               1:       e = 1;
               default: e = 0;
            endcase
         end
         gv = target - e;
         if (gv > 32767) gv = 32767;
         if (gv < -32768) gv = -32768;
         send_turn_item(gtpd_pkg::REQ_SAMPLE, DIR_NONE, 12'd0, 16'(gv), 1'b0, NO_RSP);
      end
   endtask

   // Response side ready: random short stalls, plus one long hold on request
   // so the block backs up and drops req_ready
   initial begin
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Scoreboard: every accepted response against the oldest expectation
   always @(posedge clock) begin : check_rsp
      turn_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_turn_rsp.size() == 0) begin
            $error("response transaction with nothing expected: yaw %0d err %0d done %0d",
                   rsp_yaw_drive, rsp_heading_error, rsp_done_res);
            mismatch_count++;
         end else begin
            want = pending_turn_rsp.pop_front();
            if (rsp_yaw_drive !== want.yaw) begin
               $error("yaw_drive: expected %0d, actual %0d", want.yaw, rsp_yaw_drive);
               mismatch_count++;
            end
            if (rsp_heading_error !== want.err) begin
               $error("heading_error: expected %0d, actual %0d", want.err,
                      rsp_heading_error);
               mismatch_count++;
            end
            if (rsp_done_res !== want.done) begin
               $error("done_res: expected %0d, actual %0d", want.done, rsp_done_res);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Main sequence
   initial begin : main_seq
      gain_set_type gs;
      int           active_sel;
      int           phase_end;
      req_valid          = 1'b0;
      req_type           = gtpd_pkg::REQ_START;
      req_direction      = DIR_NONE;
      req_target_degrees = '0;
      req_gyro_reading   = '0;
      csr_we             = 1'b0;
      csr_index          = gtpd_pkg::CSR_KP_GAIN;
      csr_wdata          = '0;
      active_sel         = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; registers change only between groups, with the block idle
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         if (int'(DIRECTED_ROWS[i].gain_sel) != active_sel) begin
            drain_responses();
            active_sel = int'(DIRECTED_ROWS[i].gain_sel);
            program_gains(GAIN_SETS[active_sel]);
         end
         send_turn_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].dir, DIRECTED_ROWS[i].deg,
                        DIRECTED_ROWS[i].gyro, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].rsp);
      end

      // Random phases, each under its own register image and idle mix
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_responses();
         case (phase)
            0: begin
               gs = GAIN_SETS[0];
               req_idle_pct = 25; rsp_idle_pct = 25;
            end
            1: begin
               gs = '{16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)),
                      7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      10'($urandom_range(0, 12))};
               req_idle_pct = 40; rsp_idle_pct = 40;
            end
            2: begin
               gs = '{16'hFFFF, 16'hFFFF, 7'd127, 7'd0, 10'd1023};
               req_idle_pct = 10; rsp_idle_pct = 0;
            end
            3: begin
               gs = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      10'($urandom_range(0, 6))};
               req_idle_pct = 50; rsp_idle_pct = 50;
            end
            4: begin
               gs = '{16'd0, 16'd0, 7'd0, 7'd127, 10'd1};
               req_idle_pct = 20; rsp_idle_pct = 20;
            end
            default: begin
               // tail of the run: full throughput both sides
               gs = '{16'd768, 16'd100, 7'd100, 7'd10, 10'd4};
               req_idle_pct = 0; rsp_idle_pct = 0;
            end
         endcase
         program_gains(gs);
         if (phase == 1 || phase == 4) begin
            rsp_hold_req = 1'b1;
         end
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 4) == 0) begin
               // noise: any kind, any direction code, any heading
               send_turn_item(gtpd_pkg::req_kind_type'($urandom_range(0, 1)),
                              gtpd_pkg::dir_type'($urandom_range(0, 3)),
                              12'($urandom_range(0, 3600)),
                              16'($urandom_range(0, 65535)), 1'b0, NO_RSP);
            end else begin
               run_turn_sequence(phase_end);
            end
         end
      end

      drain_responses();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/gtpd_pkg.sv
design/gyro_turn_pd_controller.sv
dv/gyro_turn_pd_controller_tb.sv
